>>> design/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, code table and duration scaling for the Morse keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int CharW  = 8;
  localparam int UnitW  = 16;
  localparam int DurW   = 18;
  localparam int UnitsW = 3;
  localparam int ElemW  = 7;
  localparam int CountW = 3;

  localparam logic [UnitsW-1:0] UNITS_NONE  = 3'd0;
  localparam logic [UnitsW-1:0] UNITS_DOT   = 3'd1;
  localparam logic [UnitsW-1:0] UNITS_GAP   = 3'd2;
  localparam logic [UnitsW-1:0] UNITS_DASH  = 3'd3;
  localparam logic [UnitsW-1:0] UNITS_SPACE = 3'd4;

  localparam logic [UnitW-1:0] UNIT_RESET = 16'd200;

  localparam logic [CharW-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CharW-1:0] CASE_OFFSET  = 8'h20;

  localparam logic [2:0] ADDR_UNIT = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ON    = 4'b0010,
    S_OFF   = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  // Marker bit, then one bit per element from the top; 1 = dash.
  function automatic logic [7:0] code_lookup(input logic [6:0] ch);
    logic [7:0] c;
    case (ch)
      7'h02: c = 8'd53;  7'h03: c = 8'd69;
      7'h22: c = 8'd82;  7'h27: c = 8'd94;  7'h28: c = 8'd54;  7'h29: c = 8'd109;
      7'h2a: c = 8'd25;  7'h2b: c = 8'd42;  7'h2c: c = 8'd115; 7'h2d: c = 8'd97;
      7'h2e: c = 8'd85;  7'h2f: c = 8'd50;
      7'h30: c = 8'd63;  7'h31: c = 8'd47;  7'h32: c = 8'd39;  7'h33: c = 8'd35;
      7'h34: c = 8'd33;  7'h35: c = 8'd32;  7'h36: c = 8'd48;  7'h37: c = 8'd56;
      7'h38: c = 8'd60;  7'h39: c = 8'd62;
      7'h3a: c = 8'd120; 7'h3d: c = 8'd49;  7'h3f: c = 8'd76;  7'h40: c = 8'd90;
      7'h41: c = 8'd5;   7'h42: c = 8'd24;  7'h43: c = 8'd26;  7'h44: c = 8'd12;
      7'h45: c = 8'd2;   7'h46: c = 8'd18;  7'h47: c = 8'd14;  7'h48: c = 8'd16;
      7'h49: c = 8'd4;   7'h4a: c = 8'd23;  7'h4b: c = 8'd13;  7'h4c: c = 8'd20;
      7'h4d: c = 8'd7;   7'h4e: c = 8'd6;   7'h4f: c = 8'd15;  7'h50: c = 8'd22;
      7'h51: c = 8'd29;  7'h52: c = 8'd10;  7'h53: c = 8'd8;   7'h54: c = 8'd3;
      7'h55: c = 8'd9;   7'h56: c = 8'd17;  7'h57: c = 8'd11;  7'h58: c = 8'd25;
      7'h59: c = 8'd27;  7'h5a: c = 8'd28;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Units 0..4 times the unit length, by shifts and one add.
  function automatic logic [DurW-1:0] scale(input logic [UnitsW-1:0] units,
                                            input logic [UnitW-1:0] ul);
    logic [DurW-1:0] u;
    logic [DurW-1:0] d;
    u = {{(DurW-UnitW){1'b0}}, ul};
    case (units)
      UNITS_DOT:   d = u;
      UNITS_GAP:   d = u << 1;
      UNITS_DASH:  d = u + (u << 1);
      UNITS_SPACE: d = u << 2;
      default:     d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> design/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// morse_character_keyer
// Turns one ASCII character into the on/off keying segments of its Morse code.
// ----------------------------------------------------------------------------
// One character is taken when the block is idle. Its code is loaded into a
// shift register and one segment leaves per cycle: an on and an off segment
// per element, then the closing gap. A space or an unsupported code gives
// only the closing segment. The input is stalled while the segments leave,
// and stall on the result channel holds the sequencer. The next character is
// taken once the closing segment sits in the output register. unit_length
// lies at address 0 of the APB port.
module morse_character_keyer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mck_pkg::CharW-1:0]   char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        key_on,
  output logic [mck_pkg::DurW-1:0]    duration,
  output logic                        unsupported,
  output logic                        last
);
  import mck_pkg::*;

  logic [UnitW-1:0]  unit_length;
  state_t            state, state_next;
  logic [ElemW-1:0]  sh;
  logic [CountW-1:0] n;
  logic [UnitsW-1:0] fin_units;
  logic              fin_unsup;

  logic              accept;
  logic              emit;
  logic [CharW-1:0]  ch;
  logic [7:0]        code;
  logic [CountW-1:0] top;
  logic [7:0]        aligned;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_UNIT[2]) ? {16'd0, unit_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_length <= UNIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_UNIT[2]) begin
      unit_length <= pwdata[UnitW-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign emit     = !out_valid || !out_stall;

  always_comb begin
    ch = char_code;
    if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
      ch = char_code - CASE_OFFSET;
    end
    code = ch[7] ? 8'd0 : code_lookup(ch[6:0]);
    top = '0;
    for (int i = 1; i < 8; i++) begin
      if (code[i]) top = CountW'(i);
    end
    aligned = code << (3'd7 - top);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (char_code == CHAR_SPACE || code < 8'd2) state_next = S_FINAL;
          else state_next = S_ON;
        end
      end
      S_ON:    if (emit) state_next = S_OFF;
      S_OFF:   if (emit) state_next = (n == CountW'(1)) ? S_FINAL : S_ON;
      S_FINAL: if (emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= (state == S_ON || state == S_OFF || state == S_FINAL);
    end
  end

  // Sequencer data path: load on accept, advance one element per on/off pair.
  always_ff @(posedge clk) begin
    if (accept) begin
      sh <= aligned[6:0];
      n  <= top;
      if (char_code == CHAR_SPACE) begin
        fin_units <= UNITS_SPACE;
        fin_unsup <= 1'b0;
      end else if (code < 8'd2) begin
        fin_units <= UNITS_NONE;
        fin_unsup <= 1'b1;
      end else begin
        fin_units <= UNITS_GAP;
        fin_unsup <= 1'b0;
      end
    end else if (state == S_OFF && emit) begin
      sh <= {sh[ElemW-2:0], 1'b0};
      n  <= n - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (state)
        S_ON: begin
          key_on      <= 1'b1;
          duration    <= scale(sh[ElemW-1] ? UNITS_DASH : UNITS_DOT, unit_length);
          unsupported <= 1'b0;
          last        <= 1'b0;
        end
        S_OFF: begin
          key_on      <= 1'b0;
          duration    <= scale(UNITS_DOT, unit_length);
          unsupported <= 1'b0;
          last        <= 1'b0;
        end
        S_FINAL: begin
          key_on      <= 1'b0;
          duration    <= scale(fin_units, unit_length);
          unsupported <= fin_unsup;
          last        <= 1'b1;
        end
        default: begin
          key_on      <= key_on;
          duration    <= duration;
          unsupported <= unsupported;
          last        <= last;
        end
      endcase
    end
  end

  a_unsup_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && unsupported |-> last && !key_on && duration == '0)
    else $error("unsupported beat malformed");

  a_elem_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_ON || state == S_OFF) |-> n != '0)
    else $error("element count empty while keying");

  a_fin_units: assert property (@(posedge clk) disable iff (rst)
    state == S_FINAL && fin_unsup |-> fin_units == UNITS_NONE)
    else $error("unsupported closing segment has units");

endmodule
